// File: rtl/tslf_pkg.sv
// Shared types and constants of the text stream line formatter.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none

package tslf_pkg;

    // Line numbers are kept as decimal digits; the counter stops at 999999.
    localparam int BCD_DIGITS = 6;
    localparam int DIGIT_CNT_W = 3;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_LETTER_I = 8'h49;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_DELETE  = 8'h7F;
    localparam logic [7:0] CTRL_LAST  = 8'h1F;
    localparam logic [7:0] CARET_OFFSET = 8'h40;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SQUEEZE_BLANK    = 3'd0,
        REG_NUMBER_NONBLANK  = 3'd1,
        REG_NUMBER_ALL       = 3'd2,
        REG_SHOW_ENDS        = 3'd3,
        REG_SHOW_TABS        = 3'd4,
        REG_SHOW_NONPRINTING = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic squeeze_blank;
        logic number_nonblank;
        logic number_all;
        logic show_ends;
        logic show_tabs;
        logic show_nonprinting;
    } cfg_t;

    // One classified input byte, as the back end expands it.
    typedef struct packed {
        logic                       number;
        logic                       pad;
        logic                       dollar;
        logic                       caret;
        logic [7:0]                 char_byte;
        logic [4*BCD_DIGITS-1:0]    digits;
        logic [DIGIT_CNT_W-1:0]     digit_cnt;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_NUM,
        PH_NUM_TAB,
        PH_PAD,
        PH_PAD_TAB,
        PH_DOLLAR,
        PH_CARET,
        PH_CHAR
    } phase_t;

endpackage

`default_nettype wire

// File: rtl/tslf_front.sv
// Front end: configuration registers, line state and classification of each byte.
// Depends on tslf_pkg.
`default_nettype none

module tslf_front (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_we,
    input  wire [tslf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire                          cfg_data,
    input  wire                          take,
    input  wire [7:0]                    in_byte,
    output logic                         push,
    output tslf_pkg::cmd_t               push_cmd
);
    import tslf_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic after_nl_reg, after_nl_next;
    logic blank_reg, blank_next;
    logic [4*BCD_DIGITS-1:0] count_reg, count_next;

    logic                    nl;
    logic                    squeezed;
    logic                    do_number;
    logic                    caret;
    logic [7:0]              ch;
    logic [DIGIT_CNT_W-1:0]  digit_cnt;
    logic                    all_nines;
    logic                    carry;
    logic [4*BCD_DIGITS-1:0] count_inc;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_SQUEEZE_BLANK:    cfg_next.squeeze_blank    = cfg_data;
                REG_NUMBER_NONBLANK:  cfg_next.number_nonblank  = cfg_data;
                REG_NUMBER_ALL:       cfg_next.number_all       = cfg_data;
                REG_SHOW_ENDS:        cfg_next.show_ends        = cfg_data;
                REG_SHOW_TABS:        cfg_next.show_tabs        = cfg_data;
                REG_SHOW_NONPRINTING: cfg_next.show_nonprinting = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        digit_cnt = DIGIT_CNT_W'(1);
        all_nines = 1'b1;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (k > 0 && count_reg[4*k +: 4] != 4'd0) begin
                digit_cnt = DIGIT_CNT_W'(k + 1);
            end
            if (count_reg[4*k +: 4] != 4'd9) begin
                all_nines = 1'b0;
            end
        end
        carry     = 1'b1;
        count_inc = count_reg;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (carry) begin
                if (count_reg[4*k +: 4] == 4'd9) begin
                    count_inc[4*k +: 4] = 4'd0;
                end else begin
                    count_inc[4*k +: 4] = count_reg[4*k +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    end

    always_comb begin
        nl       = (in_byte == CH_NEWLINE);
        squeezed = cfg_reg.squeeze_blank && nl && after_nl_reg && blank_reg;

        if (cfg_reg.number_nonblank) begin
            do_number = after_nl_reg && !nl;
        end else begin
            do_number = cfg_reg.number_all && after_nl_reg;
        end

        ch    = in_byte;
        caret = 1'b0;
        if (cfg_reg.show_tabs && in_byte == CH_TAB) begin
            caret = 1'b1;
            ch    = CH_LETTER_I;
        end
        if (cfg_reg.show_nonprinting) begin
            if (ch <= CTRL_LAST && ch != CH_TAB && ch != CH_NEWLINE) begin
                caret = 1'b1;
                ch    = ch + CARET_OFFSET;
            end else if (ch == CH_DELETE) begin
                caret = 1'b1;
                ch    = ch - CARET_OFFSET;
            end
        end

        push_cmd.number    = do_number;
        push_cmd.pad       = cfg_reg.show_ends && nl && cfg_reg.number_nonblank
                             && after_nl_reg;
        push_cmd.dollar    = cfg_reg.show_ends && nl;
        push_cmd.caret     = caret;
        push_cmd.char_byte = ch;
        push_cmd.digits    = count_reg;
        push_cmd.digit_cnt = digit_cnt;

        push = take && !squeezed;

        after_nl_next = after_nl_reg;
        blank_next    = blank_reg;
        count_next    = count_reg;
        if (take) begin
            after_nl_next = nl;
            if (cfg_reg.squeeze_blank) begin
                blank_next = nl && after_nl_reg;
            end
            if (!squeezed && do_number && !all_nines) begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= '0;
            after_nl_reg <= 1'b1;
            blank_reg    <= 1'b0;
            count_reg    <= (4*BCD_DIGITS)'(1);
        end else begin
            cfg_reg      <= cfg_next;
            after_nl_reg <= after_nl_next;
            blank_reg    <= blank_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tslf_queue.sv
// Short first-word-fall-through queue of classified bytes between front and back end.
// Depends on tslf_pkg.
`default_nettype none

module tslf_queue #(
    parameter int DEPTH = 4
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push,
    input  tslf_pkg::cmd_t  push_cmd,
    output logic            full,
    output logic            head_valid,
    output tslf_pkg::cmd_t  head,
    input  wire             pop
);
    import tslf_pkg::*;

    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t             entries [DEPTH];
    logic [AddrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AddrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AddrW:0]   count_reg, count_next;

    function automatic logic [AddrW-1:0] bump(input logic [AddrW-1:0] p);
        if (p == AddrW'(DEPTH - 1)) begin
            return '0;
        end
        return p + AddrW'(1);
    endfunction

    always_comb begin
        full       = (count_reg == (AddrW+1)'(DEPTH));
        head_valid = (count_reg != '0);
        head       = entries[rd_ptr_reg];

        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (AddrW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (AddrW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// File: rtl/tslf_back.sv
// Back end: expands each classified byte into output bytes, one per cycle unless
// m_ready holds the output back, into a registered output stage. Depends on tslf_pkg.
`default_nettype none

module tslf_back #(
    parameter int NUMBER_WIDTH = 6
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             head_valid,
    input  tslf_pkg::cmd_t  head,
    output logic            pop,
    output logic            m_valid,
    input  wire             m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last_of_run
);
    import tslf_pkg::*;

    localparam int FieldMax = (NUMBER_WIDTH > BCD_DIGITS) ? NUMBER_WIDTH : BCD_DIGITS;
    localparam int PosW     = $clog2(FieldMax);
    localparam logic [PosW-1:0] PadLast = PosW'(NUMBER_WIDTH - 1);

    logic             started_reg, started_next;
    phase_t           phase_reg, phase_next;
    logic [PosW-1:0]  pos_reg, pos_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;

    phase_t           first_phase;
    phase_t           cur_phase;
    phase_t           after_dollar;
    phase_t           after_pad_tab;
    phase_t           after_num_tab;
    logic             advance;
    logic [PosW-1:0]  nd_ext;
    logic [PosW-1:0]  num_last;
    logic [PosW-1:0]  digit_idx;
    logic [3:0]       digit;
    logic [7:0]       emit_byte;

    always_comb begin
        after_dollar  = head.caret ? PH_CARET : PH_CHAR;
        after_pad_tab = head.dollar ? PH_DOLLAR : after_dollar;
        after_num_tab = head.pad ? PH_PAD : after_pad_tab;
        first_phase   = head.number ? PH_NUM : after_num_tab;
        cur_phase     = started_reg ? phase_reg : first_phase;

        // The field widens to fit the number when it has more digits than columns.
        nd_ext    = PosW'(head.digit_cnt);
        num_last  = (nd_ext > PadLast) ? nd_ext - PosW'(1) : PadLast;
        digit_idx = num_last - pos_reg;
        digit     = 4'd0;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (digit_idx == PosW'(k)) begin
                digit = head.digits[4*k +: 4];
            end
        end

        advance = head_valid && (!m_valid_reg || m_ready);
        pop     = advance && (cur_phase == PH_CHAR);

        emit_byte  = head.char_byte;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        case (cur_phase)
            PH_NUM: begin
                emit_byte = (digit_idx < nd_ext) ? (CH_ZERO + {4'd0, digit}) : CH_SPACE;
                if (pos_reg == num_last) begin
                    phase_next = PH_NUM_TAB;
                    pos_next   = '0;
                end else begin
                    phase_next = PH_NUM;
                    pos_next   = pos_reg + PosW'(1);
                end
            end
            PH_NUM_TAB: begin
                emit_byte  = CH_TAB;
                phase_next = after_num_tab;
            end
            PH_PAD: begin
                emit_byte = CH_SPACE;
                if (pos_reg == PadLast) begin
                    phase_next = PH_PAD_TAB;
                    pos_next   = '0;
                end else begin
                    phase_next = PH_PAD;
                    pos_next   = pos_reg + PosW'(1);
                end
            end
            PH_PAD_TAB: begin
                emit_byte  = CH_TAB;
                phase_next = after_pad_tab;
            end
            PH_DOLLAR: begin
                emit_byte  = CH_DOLLAR;
                phase_next = after_dollar;
            end
            PH_CARET: begin
                emit_byte  = CH_CARET;
                phase_next = PH_CHAR;
            end
            PH_CHAR: begin
                emit_byte  = head.char_byte;
                phase_next = PH_CHAR;
                pos_next   = '0;
            end
            default: begin
                emit_byte  = head.char_byte;
                phase_next = PH_CHAR;
                pos_next   = '0;
            end
        endcase

        started_next = started_reg;
        m_valid_next = m_valid_reg && !m_ready;
        byte_next    = byte_reg;
        last_next    = last_reg;
        if (advance) begin
            started_next = !pop;
            m_valid_next = 1'b1;
            byte_next    = emit_byte;
            last_next    = (cur_phase == PH_CHAR);
        end else begin
            phase_next = phase_reg;
            pos_next   = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            phase_reg   <= PH_CHAR;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            started_reg <= started_next;
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;

`ifndef ASSERT_OFF
    a_pop_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_valid && m_last_of_run))
        else $error("completed item did not end with a last transfer");
    a_started_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |-> head_valid)
        else $error("expansion in progress without a queued item");
    a_pad_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (started_reg && phase_reg == PH_PAD) |-> (pos_reg <= PadLast))
        else $error("padding position overran the field");
`endif

endmodule

`default_nettype wire

// File: rtl/text_stream_line_formatter_unit.sv
// Top level of the text stream line formatter.
// Depends on tslf_pkg, tslf_front, tslf_queue and tslf_back.
`default_nettype none

// A byte-serial text filter with the usual cat display options: squeezing of
// repeated empty lines, line numbering, '$' at line ends, tabs as ^I and control
// bytes in caret form. The front end takes one input byte per cycle whenever the
// queue of QUEUE_DEPTH classified bytes has room; the back end then emits one
// output byte per cycle unless m_ready holds it back. An input byte produces one
// output byte for plain text, two for a caret pair, and up to NUMBER_WIDTH + 3
// (or digit count + 3 where the number is wider) for a numbered or padded line
// start. A squeezed newline is taken but produces nothing. Output bytes sit in a
// register, so the front end keeps taking input while a result waits for m_ready.
// Configuration must be written while the block is idle.
module text_stream_line_formatter_unit #(
    parameter int NUMBER_WIDTH = 6,
    parameter int QUEUE_DEPTH  = 4
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_we,
    input  wire [tslf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire                             cfg_data,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire [7:0]                       s_in_byte,
    output logic                            m_valid,
    input  wire                             m_ready,
    output logic [7:0]                      m_out_byte,
    output logic                            m_last_of_run
);
    import tslf_pkg::*;

    logic  q_full;
    logic  take;
    logic  push;
    cmd_t  push_cmd;
    logic  head_valid;
    cmd_t  head;
    logic  pop;

    assign s_ready = !q_full;
    assign take    = s_valid && !q_full;

    tslf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .in_byte   (s_in_byte),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tslf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    tslf_back #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire
